[hw/rtl/m4inv_pkg.sv]
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared constants, sequencer states and arithmetic helpers for the 4x4
// fixed-point matrix inverse unit.
// ----------------------------------------------------------------------------
package m4inv_pkg;

	localparam int DIM       = 4;
	localparam int ELEMS     = DIM * DIM;
	localparam int FRAC_BITS = 16;

	localparam logic [63:0] SMAX      = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [15:0] EPS_RESET = 16'd1;
	localparam logic        REG_EPS   = 1'b0;

	typedef enum logic [5:0] {
		ST_LOAD,
		ST_C_RDA, ST_C_RDD, ST_C_LDD, ST_C_P1, ST_C_P2, ST_C_P3,
		ST_C_RDB, ST_C_RDC, ST_C_LDC, ST_C_Q1, ST_C_Q2, ST_C_Q3,
		ST_C_RDE, ST_C_LDE, ST_C_T1, ST_C_T2, ST_C_T3,
		ST_C_ACC, ST_C_WR,
		ST_D_RD, ST_D_LD, ST_D_M1, ST_D_M2, ST_D_M3, ST_D_ACC,
		ST_CHK, ST_SING,
		ST_V_RD, ST_V_LD, ST_V_CHK, ST_V_DIV, ST_V_OUT
	} st_t;

	// k-th index of 0..3 with one index left out
	function automatic logic [1:0] sel3(input logic [1:0] skip, input logic [1:0] k);
		return (k >= skip) ? k + 2'd1 : k;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// add with symmetric clipping to +-(2^63-1)
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic signed [64:0] s;
		logic signed [64:0] hi;
		s  = $signed({a[63], a}) + $signed({b[63], b});
		hi = $signed({1'b0, SMAX});
		if (s > hi) return SMAX;
		else if (s < -hi) return ~SMAX + 64'd1;
		else return s[63:0];
	endfunction

endpackage

[hw/rtl/m4inv_ram.sv]
// ----------------------------------------------------------------------------
// m4inv_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module m4inv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/matrix4_inverse_cofactor_unit.sv]
// ----------------------------------------------------------------------------
// matrix4_inverse_cofactor_unit
// 4x4 Q16.16 matrix inverse by cofactors and the adjugate.
//
//   channel  direction  handshake            payload
//   elem     in         in_valid/in_stall    elem_value
//   inv      out        out_valid/out_stall  inv_value, singular, saturated, last
//   cfg      in         APB                  singular_epsilon at 0x0
//
// Sixteen beats load the element RAM, one per cycle. Then 16 cofactors and
// the determinant run in turn on one shared 32x32 multiplier, taking two
// partial products per 32x64 product. Each inverse element then goes
// through a 1-bit-per-cycle divider, which is skipped when the quotient
// is known to clip before division.
// in_stall is high outside loading; an output register holds the result.
// Reset sets singular_epsilon to 1 and returns to loading.
// ----------------------------------------------------------------------------
module matrix4_inverse_cofactor_unit
	import m4inv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] elem_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] inv_value,
	output logic        singular,
	output logic        saturated,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	st_t         state_q, state_d;
	logic [3:0]  load_cnt_q, cidx_q, oidx_q;
	logic [1:0]  j_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;
	logic [15:0] eps_q;

	logic [31:0] x_mag_q;
	logic        x_neg_q;
	logic [63:0] y_mag_q;
	logic        y_neg_q;
	logic [63:0] pl_q, ph_q, res_q, p_q, m2_q, acc_q, dmag_q, nmag_q, rem_q;
	logic        det_neg_q, qneg_q, big_q;
	logic [31:0] lo_q;
	logic [31:0] inv_value_q;
	logic        singular_q, saturated_q, last_q;

	logic        e_we, c_we;
	logic [3:0]  e_raddr, c_raddr;
	logic [31:0] e_rdata;
	logic [63:0] c_rdata, c_wdata;
	logic        mul_lo, mul_hi, out_load;

	logic [1:0]  row, col, sr0, sr1, sr2, u, v;
	logic        in_acc, out_free, sing;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [95:0] full, shr;
	logic [63:0] mmag, mres;
	logic [64:0] r2, rdiff;
	logic        ge, big_now, over;
	logic [31:0] limit, qv;

	assign row = cidx_q[3:2];
	assign col = cidx_q[1:0];
	assign sr0 = sel3(row, 2'd0);
	assign sr1 = sel3(row, 2'd1);
	assign sr2 = sel3(row, 2'd2);
	assign u   = sel3(col, (j_q == 2'd0) ? 2'd1 : 2'd0);
	assign v   = sel3(col, (j_q == 2'd2) ? 2'd1 : 2'd2);

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign sing     = mag64(acc_q) <= {48'd0, eps_q};

	// shared multiplier: |elem| times one half of a 64-bit magnitude
	assign mul_b = mul_hi ? y_mag_q[63:32] : y_mag_q[31:0];
	assign prod  = 64'(x_mag_q * mul_b);
	assign full  = {ph_q, 32'd0} + {32'd0, pl_q};
	assign shr   = full >> FRAC_BITS;
	assign mmag  = (|shr[95:63]) ? SMAX : shr[63:0];
	assign mres  = (x_neg_q ^ y_neg_q) ? (~mmag + 64'd1) : mmag;

	assign r2      = {rem_q, lo_q[31]};
	assign ge      = r2 >= {1'b0, dmag_q};
	assign rdiff   = r2 - {1'b0, dmag_q};
	assign big_now = {{(32 - FRAC_BITS){1'b0}}, nmag_q} >=
		{dmag_q, {(32 - FRAC_BITS){1'b0}}};
	assign limit   = qneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign over    = big_q || (lo_q > limit);
	assign qv      = over ? limit : lo_q;

	assign c_wdata = (row[0] ^ col[0]) ? (~acc_q + 64'd1) : acc_q;

	m4inv_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_elem_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (load_cnt_q),
		.wdata (elem_value),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	m4inv_ram #(.WIDTH(64), .DEPTH(ELEMS)) u_cof_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (cidx_q),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (in_acc && load_cnt_q == 4'(ELEMS - 1)) state_d = ST_C_RDA;
			ST_C_RDA: state_d = ST_C_RDD;
			ST_C_RDD: state_d = ST_C_LDD;
			ST_C_LDD: state_d = ST_C_P1;
			ST_C_P1:  state_d = ST_C_P2;
			ST_C_P2:  state_d = ST_C_P3;
			ST_C_P3:  state_d = ST_C_RDB;
			ST_C_RDB: state_d = ST_C_RDC;
			ST_C_RDC: state_d = ST_C_LDC;
			ST_C_LDC: state_d = ST_C_Q1;
			ST_C_Q1:  state_d = ST_C_Q2;
			ST_C_Q2:  state_d = ST_C_Q3;
			ST_C_Q3:  state_d = ST_C_RDE;
			ST_C_RDE: state_d = ST_C_LDE;
			ST_C_LDE: state_d = ST_C_T1;
			ST_C_T1:  state_d = ST_C_T2;
			ST_C_T2:  state_d = ST_C_T3;
			ST_C_T3:  state_d = ST_C_ACC;
			ST_C_ACC: state_d = (j_q == 2'd2) ? ST_C_WR : ST_C_RDA;
			ST_C_WR:  state_d = (cidx_q == 4'(ELEMS - 1)) ? ST_D_RD : ST_C_RDA;
			ST_D_RD:  state_d = ST_D_LD;
			ST_D_LD:  state_d = ST_D_M1;
			ST_D_M1:  state_d = ST_D_M2;
			ST_D_M2:  state_d = ST_D_M3;
			ST_D_M3:  state_d = ST_D_ACC;
			ST_D_ACC: state_d = (j_q == 2'd3) ? ST_CHK : ST_D_RD;
			ST_CHK:   state_d = sing ? ST_SING : ST_V_RD;
			ST_SING:  if (out_free) state_d = ST_LOAD;
			ST_V_RD:  state_d = ST_V_LD;
			ST_V_LD:  state_d = ST_V_CHK;
			ST_V_CHK: state_d = big_now ? ST_V_OUT : ST_V_DIV;
			ST_V_DIV: if (cnt_q == 5'd31) state_d = ST_V_OUT;
			ST_V_OUT: begin
				if (out_free) state_d = (oidx_q == 4'(ELEMS - 1)) ? ST_LOAD : ST_V_RD;
			end
			default:  state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_LOAD);
		e_we     = (state_q == ST_LOAD) && in_valid;
		c_we     = (state_q == ST_C_WR);
		e_raddr  = 4'd0;
		c_raddr  = 4'd0;
		mul_lo   = 1'b0;
		mul_hi   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_C_RDA: e_raddr = {sr1, u};
			ST_C_RDD: e_raddr = {sr2, v};
			ST_C_RDB: e_raddr = {sr1, v};
			ST_C_RDC: e_raddr = {sr2, u};
			ST_C_RDE: e_raddr = {sr0, sel3(col, j_q)};
			ST_D_RD: begin
				e_raddr = {2'd0, j_q};
				c_raddr = {2'd0, j_q};
			end
			ST_V_RD:  c_raddr = {oidx_q[1:0], oidx_q[3:2]};
			ST_C_P1, ST_C_Q1, ST_C_T1, ST_D_M1: mul_lo = 1'b1;
			ST_C_P2, ST_C_Q2, ST_C_T2, ST_D_M2: mul_hi = 1'b1;
			ST_SING, ST_V_OUT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_cnt_q  <= 4'd0;
			cidx_q      <= 4'd0;
			oidx_q      <= 4'd0;
			j_q         <= 2'd0;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
			eps_q       <= EPS_RESET;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr[2] == REG_EPS) eps_q <= pwdata[15:0];
			if (in_acc) load_cnt_q <= load_cnt_q + 4'd1;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_C_ACC: j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
				ST_C_WR:  cidx_q <= cidx_q + 4'd1;
				ST_D_ACC: j_q <= j_q + 2'd1;
				ST_V_CHK: cnt_q <= 5'd0;
				ST_V_DIV: cnt_q <= cnt_q + 5'd1;
				ST_V_OUT: if (out_free) oidx_q <= oidx_q + 4'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_lo) pl_q <= prod;
		if (mul_hi) ph_q <= prod;
		case (state_q)
			ST_LOAD: acc_q <= 64'd0;
			ST_C_RDD, ST_C_RDC, ST_C_LDE, ST_D_LD: begin
				x_mag_q <= mag32(e_rdata);
				x_neg_q <= e_rdata[31];
			end
			default: ;
		endcase
		case (state_q)
			ST_C_LDD, ST_C_LDC: begin
				y_mag_q <= {32'd0, mag32(e_rdata)};
				y_neg_q <= e_rdata[31];
			end
			ST_C_LDE: begin
				y_mag_q <= mag64(m2_q);
				y_neg_q <= m2_q[63];
			end
			ST_D_LD: begin
				y_mag_q <= mag64(c_rdata);
				y_neg_q <= c_rdata[63];
			end
			ST_C_P3, ST_C_Q3, ST_C_T3, ST_D_M3: res_q <= mres;
			ST_C_RDB: p_q <= res_q;
			ST_C_RDE: m2_q <= sat_add(p_q, ~res_q + 64'd1);
			ST_C_ACC: acc_q <= sat_add(acc_q, j_q[0] ? (~res_q + 64'd1) : res_q);
			ST_C_WR:  acc_q <= 64'd0;
			ST_D_ACC: acc_q <= sat_add(acc_q, res_q);
			ST_CHK: begin
				dmag_q    <= mag64(acc_q);
				det_neg_q <= acc_q[63];
			end
			ST_V_LD: begin
				nmag_q <= mag64(c_rdata);
				qneg_q <= c_rdata[63] ^ det_neg_q;
			end
			ST_V_CHK: begin
				big_q <= big_now;
				rem_q <= nmag_q >> (32 - FRAC_BITS);
				lo_q  <= 32'(nmag_q << FRAC_BITS);
			end
			ST_V_DIV: begin
				rem_q <= ge ? rdiff[63:0] : r2[63:0];
				lo_q  <= {lo_q[30:0], ge};
			end
			default: ;
		endcase
		if (out_load) begin
			if (state_q == ST_SING) begin
				inv_value_q <= 32'd0;
				singular_q  <= 1'b1;
				saturated_q <= 1'b0;
				last_q      <= 1'b1;
			end else begin
				inv_value_q <= qneg_q ? (~qv + 32'd1) : qv;
				singular_q  <= 1'b0;
				saturated_q <= over;
				last_q      <= (oidx_q == 4'(ELEMS - 1));
			end
		end
	end

	assign out_valid = out_valid_q;
	assign inv_value = inv_value_q;
	assign singular  = singular_q;
	assign saturated = saturated_q;
	assign last      = last_q;
	assign prdata    = (paddr[2] == REG_EPS) ? {16'd0, eps_q} : 32'd0;
	assign pready    = 1'b1;

	a_sing_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> last && !saturated && inv_value == 32'd0)
		else $error("singular beat malformed");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> inv_value == 32'h7FFF_FFFF || inv_value == 32'h8000_0000)
		else $error("clipped value out of range");

	a_load_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_C_RDA && $past(state_q) == ST_LOAD |-> load_cnt_q == 4'd0)
		else $error("load count not wrapped");

endmodule
